// File: hdl/u16u8_pkg.sv
// Shared types, constants and encoding helpers for the UTF-16 to UTF-8
// offset-map transcoder. No dependencies; used by every module in hdl/.

package u16u8_pkg;

  // Line limit and field widths
  localparam int unsigned MaxLineUnits = 65536;
  localparam int          OffW         = 17;
  localparam int          CpW          = 21;
  localparam int          QueueDepth   = 2;
  localparam int          QPtrW        = 1;
  localparam int          QCntW        = 2;

  localparam logic [OffW-1:0] LineLimit = OffW'(MaxLineUnits);

  // Surrogate ranges and the replacement character
  localparam logic [15:0]    HighFirst   = 16'hD800;
  localparam logic [15:0]    HighLast    = 16'hDBFF;
  localparam logic [15:0]    LowFirst    = 16'hDC00;
  localparam logic [15:0]    LowLast     = 16'hDFFF;
  localparam logic [CpW-1:0] Replacement = 21'h00FFFD;
  localparam logic [CpW-1:0] SuppBase    = 21'h010000;

  // One code point waiting to be encoded, with its start offset
  typedef struct packed {
    logic            v;
    logic [CpW-1:0]  cp;
    logic [OffW-1:0] off;
  } cp_slot_t;

  // Work handed from the front to the back: up to two code points and a terminal entry
  typedef struct packed {
    cp_slot_t        cp0;
    cp_slot_t        cp1;
    logic            term_v;
    logic [OffW-1:0] term_off;
  } job_t;

  // Line state seen by the top level
  typedef struct packed {
    logic            held_valid;
    logic [OffW-1:0] unit_count;
  } front_stat_t;

  // Saturating add of a small step to the unit count
  function automatic logic [OffW-1:0] sat_add(input logic [OffW-1:0] a,
                                              input logic [1:0]      b);
    logic [OffW:0] sum;
    sum = {1'b0, a} + {{(OffW-1){1'b0}}, b};
    if (sum >= {1'b0, LineLimit}) begin
      return LineLimit;
    end
    return sum[OffW-1:0];
  endfunction

  // Index of the last UTF-8 byte of a code point (length minus one)
  function automatic logic [1:0] utf8_last(input logic [CpW-1:0] cp);
    logic [1:0] res;
    priority if (cp < 21'h000080) begin
      res = 2'd0;
    end else if (cp < 21'h000800) begin
      res = 2'd1;
    end else if (cp < 21'h010000) begin
      res = 2'd2;
    end else begin
      res = 2'd3;
    end
    return res;
  endfunction

  // One UTF-8 byte of a code point, picked by its position
  function automatic logic [7:0] utf8_byte(input logic [CpW-1:0] cp,
                                           input logic [1:0]     last,
                                           input logic [1:0]     idx);
    logic [7:0] res;
    logic [1:0] sh;
    logic [5:0] tail;
    sh   = last - idx;
    tail = 6'd0;
    if (idx == 2'd0) begin
      unique case (last)
        2'd0: res = cp[7:0];
        2'd1: res = {3'b110, cp[10:6]};
        2'd2: res = {4'b1110, cp[15:12]};
        2'd3: res = {5'b11110, cp[20:18]};
      endcase
    end else begin
      unique case (sh)
        2'd0:    tail = cp[5:0];
        2'd1:    tail = cp[11:6];
        2'd2:    tail = cp[17:12];
        default: tail = 6'd0;
      endcase
      res = {2'b10, tail};
    end
    return res;
  endfunction

endpackage

// File: hdl/u16u8_front.sv
// Front end: accepts UTF-16 code units, pairs surrogates, tracks the line offset
// and builds at most one job per unit. Depends on u16u8_pkg.

module u16u8_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [15:0]            in_tdata,
  input  logic                   in_tlast,
  input  logic                   in_tuser,
  input  logic                   q_full,
  output logic                   q_push,
  output u16u8_pkg::job_t        q_wdata,
  output u16u8_pkg::front_stat_t stat
);

  logic [15:0]                held_high_r, held_high_nxt;
  logic                       held_valid_r, held_valid_nxt;
  logic [u16u8_pkg::OffW-1:0] unit_count_r, unit_count_nxt;

  logic                       accept;
  logic                       line_fin;
  logic                       is_hi;
  logic                       is_lo;
  logic [u16u8_pkg::OffW-1:0] cnt_a;
  logic [u16u8_pkg::OffW-1:0] cnt_b;
  u16u8_pkg::job_t            job;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign line_fin  = in_tlast || in_tuser;

  assign is_hi = (in_tdata >= u16u8_pkg::HighFirst) && (in_tdata <= u16u8_pkg::HighLast);
  assign is_lo = (in_tdata >= u16u8_pkg::LowFirst)  && (in_tdata <= u16u8_pkg::LowLast);

  // Classify the unit against the held high surrogate
  always_comb begin
    job            = '0;
    held_high_nxt  = held_high_r;
    held_valid_nxt = held_valid_r;
    cnt_a          = unit_count_r;
    cnt_b          = unit_count_r;

    // Held surrogate either pairs or flushes as a replacement at its own offset
    job.cp0.off = unit_count_r;
    if (held_valid_r && is_lo && !in_tuser) begin
      job.cp0.v      = 1'b1;
      job.cp0.cp     = u16u8_pkg::SuppBase + {1'b0, held_high_r[9:0], in_tdata[9:0]};
      cnt_b          = u16u8_pkg::sat_add(unit_count_r, 2'd2);
      held_valid_nxt = 1'b0;
      held_high_nxt  = 16'h0000;
    end else begin
      job.cp0.v  = held_valid_r;
      job.cp0.cp = u16u8_pkg::Replacement;
      if (held_valid_r) begin
        cnt_a = u16u8_pkg::sat_add(unit_count_r, 2'd1);
      end
      cnt_b          = cnt_a;
      held_valid_nxt = 1'b0;
      held_high_nxt  = 16'h0000;
      if (!in_tuser) begin
        job.cp1.off = cnt_a;
        if (is_hi && !in_tlast) begin
          // Hold a high surrogate until its partner or the line end
          held_valid_nxt = 1'b1;
          held_high_nxt  = in_tdata;
        end else begin
          job.cp1.v  = 1'b1;
          job.cp1.cp = (is_hi || is_lo) ? u16u8_pkg::Replacement
                                        : {5'd0, in_tdata};
          cnt_b      = u16u8_pkg::sat_add(cnt_a, 2'd1);
        end
      end
    end

    // Terminal entry closes the line and clears the state
    job.term_v     = line_fin;
    job.term_off   = cnt_b;
    unit_count_nxt = cnt_b;
    if (line_fin) begin
      held_valid_nxt = 1'b0;
      held_high_nxt  = 16'h0000;
      unit_count_nxt = '0;
    end
  end

  assign q_wdata = job;
  assign q_push  = accept && (job.cp0.v || job.cp1.v || job.term_v);

  // Advance line state on each accepted unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_high_r  <= 16'h0000;
      held_valid_r <= 1'b0;
      unit_count_r <= '0;
    end else if (accept) begin
      held_high_r  <= held_high_nxt;
      held_valid_r <= held_valid_nxt;
      unit_count_r <= unit_count_nxt;
    end
  end

  assign stat.held_valid = held_valid_r;
  assign stat.unit_count = unit_count_r;

endmodule

// File: hdl/u16u8_queue.sv
// Short job queue between the front and back ends.
// Depends on u16u8_pkg for the job type and depth.

module u16u8_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  u16u8_pkg::job_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            rd_valid,
  output u16u8_pkg::job_t rdata
);

  u16u8_pkg::job_t             mem_r [u16u8_pkg::QueueDepth];
  logic [u16u8_pkg::QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [u16u8_pkg::QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [u16u8_pkg::QCntW-1:0] count_r, count_nxt;
  logic                        do_push;
  logic                        do_pop;

  assign full     = (count_r == u16u8_pkg::QCntW'(u16u8_pkg::QueueDepth));
  assign rd_valid = (count_r != '0);
  assign rdata    = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (do_push ? 1'b1 : 1'b0);
    rd_ptr_nxt = rd_ptr_r + (do_pop ? 1'b1 : 1'b0);
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the job at the write pointer
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: hdl/u16u8_back.sv
// Back end: walks each job and emits one UTF-8 byte or terminal word per cycle
// through an output register while a job waits and the output is taken. Depends on u16u8_pkg.

module u16u8_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  u16u8_pkg::job_t head,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [31:0]     out_tdata,
  output logic            out_tlast,
  output logic            out_tuser
);

  localparam logic [1:0] SLOT_CP0  = 2'd0;
  localparam logic [1:0] SLOT_CP1  = 2'd1;
  localparam logic [1:0] SLOT_TERM = 2'd2;

  logic [1:0]                 slot_r, slot_nxt;
  logic [1:0]                 byte_r, byte_nxt;
  logic                       out_valid_r;
  logic [7:0]                 out_byte_r;
  logic [u16u8_pkg::OffW-1:0] out_off_r;
  logic                       out_term_r;
  logic                       out_last_r;

  logic [1:0]                 cur;
  logic [u16u8_pkg::CpW-1:0]  cur_cp;
  logic [u16u8_pkg::OffW-1:0] cur_off;
  logic [1:0]                 cur_last;
  logic [7:0]                 cur_byte;
  logic                       cur_term;
  logic                       slot_end;
  logic                       later;
  logic                       job_end;
  logic                       load;

  // Pick the first pending slot of the head job
  always_comb begin
    priority if (slot_r == SLOT_CP0 && head.cp0.v) begin
      cur = SLOT_CP0;
    end else if (slot_r != SLOT_TERM && head.cp1.v) begin
      cur = SLOT_CP1;
    end else begin
      cur = SLOT_TERM;
    end
  end

  // Encode the current byte
  always_comb begin
    cur_term = 1'b0;
    unique case (cur)
      SLOT_CP0: begin
        cur_cp  = head.cp0.cp;
        cur_off = head.cp0.off;
        later   = head.cp1.v || head.term_v;
      end
      SLOT_CP1: begin
        cur_cp  = head.cp1.cp;
        cur_off = head.cp1.off;
        later   = head.term_v;
      end
      default: begin
        cur_cp   = '0;
        cur_off  = head.term_off;
        later    = 1'b0;
        cur_term = 1'b1;
      end
    endcase
    cur_last = cur_term ? 2'd0 : u16u8_pkg::utf8_last(cur_cp);
    cur_byte = cur_term ? 8'h00 : u16u8_pkg::utf8_byte(cur_cp, cur_last, byte_r);
    slot_end = (byte_r == cur_last);
    job_end  = slot_end && !later;
  end

  assign load = head_valid && (!out_valid_r || out_tready);
  assign pop  = load && job_end;

  // Step through bytes and slots
  always_comb begin
    slot_nxt = slot_r;
    byte_nxt = byte_r;
    if (load) begin
      if (job_end) begin
        slot_nxt = SLOT_CP0;
        byte_nxt = 2'd0;
      end else if (slot_end) begin
        slot_nxt = cur + 2'd1;
        byte_nxt = 2'd0;
      end else begin
        slot_nxt = cur;
        byte_nxt = byte_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= SLOT_CP0;
      byte_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
      byte_r <= byte_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the output word until taken
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= cur_byte;
      out_off_r  <= cur_off;
      out_term_r <= cur_term;
      out_last_r <= job_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_off_r, out_byte_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_term_r;

endmodule

// File: hdl/utf16_to_utf8_offset_map.sv
// Flow: a code unit's job passes through the job queue and then the back end's output
// register before its first result word is valid on the output.
// Throughput: one output word per cycle from the byte sequencer in the back end
// while the output is taken; a unit causes up to seven words, and a held high
// surrogate causes none. The front accepts new units until the job queue is full.
// Reset: synchronous, active low; clears the held surrogate, offset, queue and
// output valid.

module utf16_to_utf8_offset_map (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] code_unit
  input  logic        in_tlast,   // line_end
  input  logic        in_tuser,   // empty_line
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] utf8_byte, [24:8] unit_offset, [31:25] zero
  output logic        out_tlast,  // last_result
  output logic        out_tuser   // terminal
);

  logic                   q_push;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_valid;
  u16u8_pkg::job_t        q_wdata;
  u16u8_pkg::job_t        q_rdata;
  u16u8_pkg::front_stat_t front_stat;

  u16u8_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata),
    .stat      (front_stat)
  );

  u16u8_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rdata    (q_rdata)
  );

  u16u8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head       (q_rdata),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

`ifndef NO_ASSERTIONS
  // A terminal entry always closes its item's run
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("terminal entry without last_result");

  // A terminal entry carries a zero byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[7:0] == 8'h00)
    else $error("terminal entry with non-zero byte");

  // Line end clears the held surrogate and the offset
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tlast || in_tuser) |=>
      !front_stat.held_valid && front_stat.unit_count == '0)
    else $error("line state not cleared after line end");

  // The offset never passes the line limit
  assert property (@(posedge clk) disable iff (!rst_n)
    front_stat.unit_count <= u16u8_pkg::LineLimit)
    else $error("unit count beyond line limit");
`endif

endmodule
